// ===== hdl/wps_pkg.sv =====
// Shared types and constants of the wildcard pattern scanner.
package wps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_FIRST = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LAST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WILD_VALUES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WILD_COUNT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALIGNMENT     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LIMIT    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS  = 3'd7;

    localparam logic [4:0]  ALIGN_MAX  = 5'd16;
    localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] mem_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] match_address;
    } out_item_t;

    // Derived scan settings handed from the register file to the core
    typedef struct packed {
        logic [4:0]  len_m1;      // pattern length minus one
        logic        cand_ok;     // nonzero length and nonzero alignment
        logic [4:0]  align;       // saturated alignment
        logic [31:0] scan_limit;
        logic [31:0] base;
    } cfg_t;

endpackage

// ===== hdl/wps_cfg.sv =====
// Configuration registers and the registered per-position pattern compare setup.
module wps_cfg #(
    parameter int PATTERN_MAX  = 16,
    parameter int WILDCARD_MAX = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wps_pkg::cfg_t                      cfg,
    output logic [PATTERN_MAX-1:0][7:0]        expect_byte,
    output logic [PATTERN_MAX-1:0]             wild,
    output logic [PATTERN_MAX-1:0]             in_use
);
    import wps_pkg::*;

    localparam logic [6:0] PatMax7  = 7'(PATTERN_MAX);
    localparam logic [3:0] WildMax4 = 4'(WILDCARD_MAX);

    logic [63:0] pat_first_reg, pat_last_reg, wild_values_reg;
    logic [4:0]  pat_len_reg, align_reg;
    logic [3:0]  wild_count_reg;
    logic [31:0] scan_limit_reg, base_reg;

    logic [4:0]                  len_sat, align_sat;
    logic [3:0]                  wc_sat;
    logic [PATTERN_MAX-1:0][7:0] pat_all;
    logic [PATTERN_MAX-1:0][7:0] exp_next;
    logic [PATTERN_MAX-1:0]      wild_next, use_next;
    cfg_t                        cfg_next;

    logic [PATTERN_MAX-1:0][7:0] exp_reg;
    logic [PATTERN_MAX-1:0]      wild_reg, use_reg;
    cfg_t                        cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_first_reg   <= '0;
            pat_last_reg    <= '0;
            pat_len_reg     <= 5'd1;
            wild_values_reg <= '0;
            wild_count_reg  <= '0;
            align_reg       <= 5'd1;
            scan_limit_reg  <= '0;
            base_reg        <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_FIRST: pat_first_reg   <= cfg_data;
                REG_PATTERN_LAST:  pat_last_reg    <= cfg_data;
                REG_PATTERN_LEN:   pat_len_reg     <= cfg_data[4:0];
                REG_WILD_VALUES:   wild_values_reg <= cfg_data;
                REG_WILD_COUNT:    wild_count_reg  <= cfg_data[3:0];
                REG_ALIGNMENT:     align_reg       <= cfg_data[4:0];
                REG_SCAN_LIMIT:    scan_limit_reg  <= cfg_data[31:0];
                REG_BASE_ADDRESS:  base_reg        <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    // Saturate the counts and lay the pattern out newest byte first, so the
    // core compares each window tap against a fixed register.
    always_comb
    begin
        len_sat   = ({2'b00, pat_len_reg} > PatMax7) ? PatMax7[4:0] : pat_len_reg;
        align_sat = (align_reg > ALIGN_MAX) ? ALIGN_MAX : align_reg;
        wc_sat    = (wild_count_reg > WildMax4) ? WildMax4 : wild_count_reg;

        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (i < 8)
                pat_all[i] = pat_first_reg[8*i +: 8];
            else if (i < 16)
                pat_all[i] = pat_last_reg[8*(i-8) +: 8];
            else
                pat_all[i] = 8'd0;
        end

        cfg_next.len_m1     = len_sat - 5'd1;
        cfg_next.cand_ok    = (len_sat != 5'd0) && (align_sat != 5'd0);
        cfg_next.align      = align_sat;
        cfg_next.scan_limit = scan_limit_reg;
        cfg_next.base       = base_reg;

        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            use_next[k] = (7'(k) < {2'b00, len_sat});
            exp_next[k] = 8'd0;
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (7'(i) + 7'(k) == {2'b00, cfg_next.len_m1})
                    exp_next[k] = pat_all[i];
            end
            wild_next[k] = 1'b0;
            for (int j = 0; j < WILDCARD_MAX; j++)
            begin
                if ((4'(j) < wc_sat) && (wild_values_reg[8*j +: 8] == exp_next[k]))
                    wild_next[k] = 1'b1;
            end
        end
    end

    // Settings must change only while idle (unenforced): the added delay is unseen.
    always_ff @(posedge clk)
    begin
        cfg_reg  <= cfg_next;
        exp_reg  <= exp_next;
        wild_reg <= wild_next;
        use_reg  <= use_next;
    end

    assign cfg         = cfg_reg;
    assign expect_byte = exp_reg;
    assign wild        = wild_reg;
    assign in_use      = use_reg;

endmodule

// ===== hdl/wps_core.sv =====
// Scan state, byte window and the single-pass candidate compare.
module wps_core #(
    parameter int          PATTERN_MAX = 16,
    parameter logic [31:0] ADDR_MASK   = 32'hFFFF_FFFF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  wps_pkg::in_item_t            item,
    input  wps_pkg::cfg_t                cfg,
    input  logic [PATTERN_MAX-1:0][7:0]  expect_byte,
    input  logic [PATTERN_MAX-1:0]       wild,
    input  logic [PATTERN_MAX-1:0]       in_use,
    output logic                         produce,
    output wps_pkg::out_item_t           result
);
    import wps_pkg::*;

    localparam int WinDepth = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;

    logic [WinDepth-1:0][7:0]    win_reg, win_next;
    logic [31:0]                 seen_reg, seen_next;
    logic [3:0]                  phase_reg, phase_next;
    logic                        given_reg, given_next;

    logic [PATTERN_MAX-1:0][7:0] seq;
    logic                        all_match, eligible, hit;
    logic [31:0]                 start;
    logic [4:0]                  ph, ph_inc;

    always_comb
    begin
        seq[0] = item.mem_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
            seq[k] = win_reg[k-1];

        all_match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (in_use[k] && !wild[k] && (seq[k] != expect_byte[k]))
                all_match = 1'b0;
        end

        eligible = !given_reg && cfg.cand_ok && (seen_reg != OFFSET_MAX)
                   && (seen_reg >= {27'd0, cfg.len_m1});
        start    = seen_reg - {27'd0, cfg.len_m1};
        ph       = ({1'b0, phase_reg} >= cfg.align) ? 5'd0 : {1'b0, phase_reg};
        ph_inc   = ph + 5'd1;
        hit      = eligible && (ph == 5'd0) && (start < cfg.scan_limit) && all_match;

        win_next[0] = item.mem_byte;
        for (int j = 1; j < WinDepth; j++)
            win_next[j] = win_reg[j-1];

        seen_next  = (seen_reg == OFFSET_MAX) ? seen_reg : seen_reg + 32'd1;
        phase_next = phase_reg;
        if (eligible)
            phase_next = (ph_inc >= cfg.align) ? 4'd0 : ph_inc[3:0];
        given_next = given_reg || hit;

        // The last byte of a region restarts the scan
        if (item.final_byte)
        begin
            seen_next  = '0;
            phase_next = '0;
            given_next = 1'b0;
        end

        produce              = hit || (item.final_byte && !given_reg);
        result.found         = hit;
        result.match_address = hit ? ((cfg.base + start) & ADDR_MASK) : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            phase_reg <= '0;
            given_reg <= 1'b0;
        end
        else if (step)
        begin
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
            given_reg <= given_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            win_reg <= win_next;
    end

endmodule

// ===== hdl/wildcard_pattern_scanner.sv =====
// Top level of the wildcard byte pattern scanner: handshake, input and result registers.
//
// Streams memory bytes, one beat per byte in address order, and reports the
// first aligned start offset below scan_limit where every pattern byte equals
// the memory byte or is one of the wildcard values. One result beat per
// region: found with base_address plus the offset, or not-found (address
// zero) when the beat marked final_byte arrives without a hit; bytes after a
// hit are dropped until the final byte, which restarts the scan. The block
// takes one byte per cycle while the output is not stalled; the byte that
// completes a candidate passes the input register, then the result register.
// The input stalls only when the result register is full and stalled and a
// byte already waits in the input register. Configuration writes take effect
// for the next byte and must be made while the block is idle; the derived
// compare setup is registered once more after the write.
module wildcard_pattern_scanner #(
    parameter int PATTERN_MAX  = 16,
    parameter int WILDCARD_MAX = 8,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  wps_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output wps_pkg::out_item_t               out_item
);
    import wps_pkg::*;

    // Address bits above ADDRESS_BITS read as zero
    localparam logic [31:0] AddrMask = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

    cfg_t                        cfg;
    logic [PATTERN_MAX-1:0][7:0] expect_byte;
    logic [PATTERN_MAX-1:0]      wild;
    logic [PATTERN_MAX-1:0]      in_use;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      out_free, advance, take_in, produce;
    out_item_t result;

    wps_cfg #(
        .PATTERN_MAX  (PATTERN_MAX),
        .WILDCARD_MAX (WILDCARD_MAX)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .expect_byte (expect_byte),
        .wild        (wild),
        .in_use      (in_use)
    );

    wps_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .ADDR_MASK   (AddrMask)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (s1_item_reg),
        .cfg         (cfg),
        .expect_byte (expect_byte),
        .wild        (wild),
        .in_use      (in_use),
        .produce     (produce),
        .result      (result)
    );

    // Advance the held byte whenever the result register can take a beat
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= produce;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold payloads while stalled; load only on a moving beat
    always_ff @(posedge clk)
    begin
        if (take_in)
            s1_item_reg <= in_item;
        if (advance && produce)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
